@@ hw/rtl/lav_pkg.sv @@
`timescale 1ns / 1ps

package lav_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IW = 32;
   localparam int DW = IW + 1;
   localparam int FW = FRAC_BITS + 2;
   localparam int VW = FW + IW + 1;
   localparam int MW = VW;
   localparam int SW = 2 * MW + 2;
   localparam int RW = MW + 1;
   localparam int QW = FRAC_BITS + 1;
   localparam int UW = 2 * FW + 1 - FRAC_BITS;
   localparam int NORM_LAT = 5 + RW + QW;

   localparam logic [1:0] LAST_COL = 2'd3;
   localparam logic [IW-1:0] ONE_Q = IW'(1) << FRAC_BITS;

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   typedef logic [2:0][IW-1:0] vec_type;
   typedef logic [2:0][FW-1:0] unit_vec_type;
   typedef logic [3:0][2:0][IW-1:0] mat_type;

   function automatic logic signed [63:0] drop_frac(input logic signed [63:0] x);
      logic [63:0] m;
      m = x[63] ? -x : x;
      m = m >> FRAC_BITS;
      return x[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [IW-1:0] sat32(input logic signed [63:0] x);
      if (x > SAT_MAX) begin
         return SAT_MAX[IW-1:0];
      end
      if (x < SAT_MIN) begin
         return SAT_MIN[IW-1:0];
      end
      return x[IW-1:0];
   endfunction

endpackage

@@ hw/rtl/look_at_view_matrix.sv @@
// Column 0 of an accepted item's result comes out first; columns 1-3 follow.
// The four-column result serializer holds each item until its last column is taken;
// the pipeline itself takes an item every cycle until it backs up behind that stage.
// Each normalize unit is 74 stages: magnitudes, squares, sum, bit-serial root, bit-serial divide, sign.
// Reset (synchronous, active high) clears all valid bits; items in flight are dropped.
`timescale 1ns / 1ps

module look_at_view_matrix (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [31:0]   req_eye_x,
   input  logic [31:0]   req_eye_y,
   input  logic [31:0]   req_eye_z,
   input  logic [31:0]   req_center_x,
   input  logic [31:0]   req_center_y,
   input  logic [31:0]   req_center_z,
   input  logic [31:0]   req_up_x,
   input  logic [31:0]   req_up_y,
   input  logic [31:0]   req_up_z,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_column,
   output logic [31:0]   rsp_elem_row0,
   output logic [31:0]   rsp_elem_row1,
   output logic [31:0]   rsp_elem_row2,
   output logic [31:0]   rsp_elem_row3,
   output logic          rsp_last
);

   localparam int IW  = lav_pkg::IW;
   localparam int DW  = lav_pkg::DW;
   localparam int FW  = lav_pkg::FW;
   localparam int VW  = lav_pkg::VW;
   localparam int UW  = lav_pkg::UW;
   localparam int LAT = lav_pkg::NORM_LAT;
   localparam int PW  = FW + IW;
   localparam int RPW = 2 * FW;

   typedef struct packed {
      lav_pkg::vec_type eye;
      lav_pkg::vec_type up;
   } side1_type;

   typedef struct packed {
      lav_pkg::vec_type      eye;
      lav_pkg::unit_vec_type f;
   } side2_type;

   logic adv;
   logic cols_rdy;

   // stage 1: difference
   logic                  t1_vld_ff;
   lav_pkg::vec_type      t1_eye_ff;
   lav_pkg::vec_type      t1_up_ff;
   logic [2:0][DW-1:0]    t1_d_ff;
   logic [2:0][VW-1:0]    n1_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_vld_ff <= 1'b0;
      end else if (adv) begin
         t1_vld_ff <= req_valid;
      end
      if (adv) begin
         t1_eye_ff <= {req_eye_z, req_eye_y, req_eye_x};
         t1_up_ff  <= {req_up_z, req_up_y, req_up_x};
         t1_d_ff[0] <= DW'($signed(req_center_x)) - DW'($signed(req_eye_x));
         t1_d_ff[1] <= DW'($signed(req_center_y)) - DW'($signed(req_eye_y));
         t1_d_ff[2] <= DW'($signed(req_center_z)) - DW'($signed(req_eye_z));
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         n1_in[c] = VW'($signed(t1_d_ff[c]));
      end
   end

   logic                  n1_vld;
   lav_pkg::unit_vec_type n1_f;

   lav_norm u_norm_f (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (t1_vld_ff),
      .in_v      (n1_in),
      .out_valid (n1_vld),
      .out_f     (n1_f)
   );

   side1_type sd1_ff [LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         sd1_ff[0] <= '{eye: t1_eye_ff, up: t1_up_ff};
         for (int k = 1; k < LAT; k++) begin
            sd1_ff[k] <= sd1_ff[k-1];
         end
      end
   end

   // stage 2: cross products f x up
   logic                  t2_vld_ff;
   logic [5:0][PW-1:0]    t2_p_ff;
   side2_type             t2_sd_ff;
   lav_pkg::vec_type      up1;

   assign up1 = sd1_ff[LAT-1].up;

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_vld_ff <= 1'b0;
      end else if (adv) begin
         t2_vld_ff <= n1_vld;
      end
      if (adv) begin
         t2_p_ff[0] <= $signed(n1_f[1]) * $signed(up1[2]);
         t2_p_ff[1] <= $signed(n1_f[2]) * $signed(up1[1]);
         t2_p_ff[2] <= $signed(n1_f[2]) * $signed(up1[0]);
         t2_p_ff[3] <= $signed(n1_f[0]) * $signed(up1[2]);
         t2_p_ff[4] <= $signed(n1_f[0]) * $signed(up1[1]);
         t2_p_ff[5] <= $signed(n1_f[1]) * $signed(up1[0]);
         t2_sd_ff   <= '{eye: sd1_ff[LAT-1].eye, f: n1_f};
      end
   end

   // stage 3: side vector before normalize
   logic                  t3_vld_ff;
   logic [2:0][VW-1:0]    t3_sr_ff;
   side2_type             t3_sd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t3_vld_ff <= 1'b0;
      end else if (adv) begin
         t3_vld_ff <= t2_vld_ff;
      end
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            t3_sr_ff[c] <= VW'($signed(t2_p_ff[2*c])) - VW'($signed(t2_p_ff[2*c+1]));
         end
         t3_sd_ff <= t2_sd_ff;
      end
   end

   logic                  n2_vld;
   lav_pkg::unit_vec_type n2_s;

   lav_norm u_norm_s (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (t3_vld_ff),
      .in_v      (t3_sr_ff),
      .out_valid (n2_vld),
      .out_f     (n2_s)
   );

   side2_type sd2_ff [LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         sd2_ff[0] <= t3_sd_ff;
         for (int k = 1; k < LAT; k++) begin
            sd2_ff[k] <= sd2_ff[k-1];
         end
      end
   end

   // stage 4: s x f products and dot product terms
   logic                  t4_vld_ff;
   logic [5:0][RPW-1:0]   t4_r_ff;
   logic [2:0][PW-1:0]    t4_se_ff;
   logic [2:0][PW-1:0]    t4_fe_ff;
   lav_pkg::unit_vec_type t4_s_ff;
   side2_type             t4_sd_ff;
   side2_type             sd2o;

   assign sd2o = sd2_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         t4_vld_ff <= 1'b0;
      end else if (adv) begin
         t4_vld_ff <= n2_vld;
      end
      if (adv) begin
         t4_r_ff[0] <= $signed(n2_s[1]) * $signed(sd2o.f[2]);
         t4_r_ff[1] <= $signed(n2_s[2]) * $signed(sd2o.f[1]);
         t4_r_ff[2] <= $signed(n2_s[2]) * $signed(sd2o.f[0]);
         t4_r_ff[3] <= $signed(n2_s[0]) * $signed(sd2o.f[2]);
         t4_r_ff[4] <= $signed(n2_s[0]) * $signed(sd2o.f[1]);
         t4_r_ff[5] <= $signed(n2_s[1]) * $signed(sd2o.f[0]);
         for (int c = 0; c < 3; c++) begin
            t4_se_ff[c] <= $signed(n2_s[c]) * $signed(sd2o.eye[c]);
            t4_fe_ff[c] <= $signed(sd2o.f[c]) * $signed(sd2o.eye[c]);
         end
         t4_s_ff  <= n2_s;
         t4_sd_ff <= sd2o;
      end
   end

   // stage 5: sums
   logic                  t5_vld_ff;
   logic [2:0][RPW:0]     t5_ur_ff;
   logic signed [63:0]    t5_sdot_ff;
   logic signed [63:0]    t5_fdot_ff;
   lav_pkg::unit_vec_type t5_s_ff;
   side2_type             t5_sd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t5_vld_ff <= 1'b0;
      end else if (adv) begin
         t5_vld_ff <= t4_vld_ff;
      end
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            t5_ur_ff[c] <= (RPW+1)'($signed(t4_r_ff[2*c]))
                         - (RPW+1)'($signed(t4_r_ff[2*c+1]));
         end
         t5_sdot_ff <= 64'($signed(t4_se_ff[0])) + 64'($signed(t4_se_ff[1]))
                     + 64'($signed(t4_se_ff[2]));
         t5_fdot_ff <= 64'($signed(t4_fe_ff[0])) + 64'($signed(t4_fe_ff[1]))
                     + 64'($signed(t4_fe_ff[2]));
         t5_s_ff  <= t4_s_ff;
         t5_sd_ff <= t4_sd_ff;
      end
   end

   // stage 6: scale back, column 3 rows 0 and 2
   logic                  t6_vld_ff;
   logic [2:0][UW-1:0]    t6_u_ff;
   logic [IW-1:0]         t6_r0_ff;
   logic [IW-1:0]         t6_r2_ff;
   lav_pkg::unit_vec_type t6_s_ff;
   side2_type             t6_sd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t6_vld_ff <= 1'b0;
      end else if (adv) begin
         t6_vld_ff <= t5_vld_ff;
      end
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            t6_u_ff[c] <= UW'(lav_pkg::drop_frac(64'($signed(t5_ur_ff[c]))));
         end
         t6_r0_ff <= lav_pkg::sat32(-lav_pkg::drop_frac(t5_sdot_ff));
         t6_r2_ff <= lav_pkg::sat32(lav_pkg::drop_frac(t5_fdot_ff));
         t6_s_ff  <= t5_s_ff;
         t6_sd_ff <= t5_sd_ff;
      end
   end

   // stage 7: u dot eye terms
   logic                      t7_vld_ff;
   logic [2:0][UW+IW-1:0]     t7_ue_ff;
   logic [2:0][UW-1:0]        t7_u_ff;
   logic [IW-1:0]             t7_r0_ff;
   logic [IW-1:0]             t7_r2_ff;
   lav_pkg::unit_vec_type     t7_s_ff;
   lav_pkg::unit_vec_type     t7_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t7_vld_ff <= 1'b0;
      end else if (adv) begin
         t7_vld_ff <= t6_vld_ff;
      end
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            t7_ue_ff[c] <= $signed(t6_u_ff[c]) * $signed(t6_sd_ff.eye[c]);
         end
         t7_u_ff  <= t6_u_ff;
         t7_r0_ff <= t6_r0_ff;
         t7_r2_ff <= t6_r2_ff;
         t7_s_ff  <= t6_s_ff;
         t7_f_ff  <= t6_sd_ff.f;
      end
   end

   // stage 8: assemble matrix
   logic                  t8_vld_ff;
   lav_pkg::mat_type      t8_mat_ff;
   lav_pkg::mat_type      t8_mat_in;
   logic signed [63:0]    udot;

   always_comb begin
      udot = 64'($signed(t7_ue_ff[0])) + 64'($signed(t7_ue_ff[1]))
           + 64'($signed(t7_ue_ff[2]));
      for (int c = 0; c < 3; c++) begin
         t8_mat_in[c][0] = lav_pkg::sat32(64'($signed(t7_s_ff[c])));
         t8_mat_in[c][1] = lav_pkg::sat32(64'($signed(t7_u_ff[c])));
         t8_mat_in[c][2] = lav_pkg::sat32(-64'($signed(t7_f_ff[c])));
      end
      t8_mat_in[3][0] = t7_r0_ff;
      t8_mat_in[3][1] = lav_pkg::sat32(-lav_pkg::drop_frac(udot));
      t8_mat_in[3][2] = t7_r2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t8_vld_ff <= 1'b0;
      end else if (adv) begin
         t8_vld_ff <= t7_vld_ff;
      end
      if (adv) begin
         t8_mat_ff <= t8_mat_in;
      end
   end

   assign adv       = !t8_vld_ff || cols_rdy;
   assign req_stall = !adv;

   lav_cols u_cols (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (t8_vld_ff),
      .in_mat        (t8_mat_ff),
      .in_ready      (cols_rdy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_column    (rsp_column),
      .rsp_elem_row0 (rsp_elem_row0),
      .rsp_elem_row1 (rsp_elem_row1),
      .rsp_elem_row2 (rsp_elem_row2),
      .rsp_elem_row3 (rsp_elem_row3),
      .rsp_last      (rsp_last)
   );

endmodule

@@ hw/rtl/lav_norm.sv @@
`timescale 1ns / 1ps

module lav_norm (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  logic [2:0][lav_pkg::VW-1:0]              in_v,
   output logic                                     out_valid,
   output lav_pkg::unit_vec_type                    out_f
);

   localparam int MW = lav_pkg::MW;
   localparam int SW = lav_pkg::SW;
   localparam int RW = lav_pkg::RW;
   localparam int QW = lav_pkg::QW;
   localparam int FW = lav_pkg::FW;
   localparam int FB = lav_pkg::FRAC_BITS;
   localparam int LW = 32;
   localparam int HW = MW - LW;

   // magnitudes
   logic                      a_vld_ff;
   logic [2:0][MW-1:0]        a_mag_ff;
   logic [2:0][MW-1:0]        a_mag_in;
   logic [2:0]                a_neg_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         a_mag_in[c] = in_v[c][MW-1] ? -in_v[c] : in_v[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_valid;
      end
      if (en) begin
         a_mag_ff <= a_mag_in;
         for (int c = 0; c < 3; c++) begin
            a_neg_ff[c] <= in_v[c][MW-1];
         end
      end
   end

   // partial products of the squares
   logic                      b_vld_ff;
   logic [2:0][2*LW-1:0]      b_ll_ff;
   logic [2:0][LW+HW-1:0]     b_lh_ff;
   logic [2:0][2*HW-1:0]      b_hh_ff;
   logic [2:0][MW-1:0]        b_mag_ff;
   logic [2:0]                b_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            b_ll_ff[c] <= a_mag_ff[c][LW-1:0] * a_mag_ff[c][LW-1:0];
            b_lh_ff[c] <= a_mag_ff[c][LW-1:0] * a_mag_ff[c][MW-1:LW];
            b_hh_ff[c] <= a_mag_ff[c][MW-1:LW] * a_mag_ff[c][MW-1:LW];
         end
         b_mag_ff <= a_mag_ff;
         b_neg_ff <= a_neg_ff;
      end
   end

   // squares
   logic                      c_vld_ff;
   logic [2:0][2*MW-1:0]      c_sq_ff;
   logic [2:0][MW-1:0]        c_mag_ff;
   logic [2:0]                c_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= b_vld_ff;
      end
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            c_sq_ff[c] <= ((2*MW)'(b_hh_ff[c]) << (2*LW))
                        + ((2*MW)'(b_lh_ff[c]) << (LW+1))
                        + (2*MW)'(b_ll_ff[c]);
         end
         c_mag_ff <= b_mag_ff;
         c_neg_ff <= b_neg_ff;
      end
   end

   // sum of squares
   logic                      d_vld_ff;
   logic [SW-1:0]             d_sum_ff;
   logic [2:0][MW-1:0]        d_mag_ff;
   logic [2:0]                d_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= c_vld_ff;
      end
      if (en) begin
         d_sum_ff <= SW'(c_sq_ff[0]) + SW'(c_sq_ff[1]) + SW'(c_sq_ff[2]);
         d_mag_ff <= c_mag_ff;
         d_neg_ff <= c_neg_ff;
      end
   end

   // square root, one result bit per stage
   logic                      sq_vld_ff  [RW];
   logic [SW-1:0]             sq_rad_ff  [RW];
   logic [RW:0]               sq_rem_ff  [RW];
   logic [RW-1:0]             sq_root_ff [RW];
   logic [2:0][MW-1:0]        sq_mag_ff  [RW];
   logic [2:0]                sq_neg_ff  [RW];

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      logic                vld_i;
      logic [SW-1:0]       rad_i;
      logic [RW:0]         rem_i;
      logic [RW-1:0]       root_i;
      logic [2:0][MW-1:0]  mag_i;
      logic [2:0]          neg_i;
      logic [RW+2:0]       t;
      logic [RW+2:0]       trial;
      logic [RW:0]         rem_n;
      logic [RW-1:0]       root_n;

      if (k == 0) begin : g_first
         assign vld_i  = d_vld_ff;
         assign rad_i  = d_sum_ff;
         assign rem_i  = '0;
         assign root_i = '0;
         assign mag_i  = d_mag_ff;
         assign neg_i  = d_neg_ff;
      end else begin : g_next
         assign vld_i  = sq_vld_ff[k-1];
         assign rad_i  = sq_rad_ff[k-1];
         assign rem_i  = sq_rem_ff[k-1];
         assign root_i = sq_root_ff[k-1];
         assign mag_i  = sq_mag_ff[k-1];
         assign neg_i  = sq_neg_ff[k-1];
      end

      always_comb begin
         t     = {rem_i, rad_i[SW-1 -: 2]};
         trial = {1'b0, root_i, 2'b01};
         if (t >= trial) begin
            rem_n  = (RW+1)'(t - trial);
            root_n = {root_i[RW-2:0], 1'b1};
         end else begin
            rem_n  = t[RW:0];
            root_n = {root_i[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k] <= 1'b0;
         end else if (en) begin
            sq_vld_ff[k] <= vld_i;
         end
         if (en) begin
            sq_rad_ff[k]  <= rad_i << 2;
            sq_rem_ff[k]  <= rem_n;
            sq_root_ff[k] <= root_n;
            sq_mag_ff[k]  <= mag_i;
            sq_neg_ff[k]  <= neg_i;
         end
      end
   end

   // restoring division of (mag << FRAC_BITS) by the root, one bit per stage
   logic                      dv_vld_ff [QW];
   logic [2:0][RW:0]          dv_rem_ff [QW];
   logic [2:0][QW-1:0]        dv_q_ff   [QW];
   logic [RW-1:0]             dv_n_ff   [QW];
   logic [2:0][MW-1:0]        dv_mag_ff [QW];
   logic [2:0]                dv_neg_ff [QW];

   for (genvar j = 0; j < QW; j++) begin : g_div
      logic                vld_i;
      logic [2:0][RW:0]    rem_i;
      logic [2:0][QW-1:0]  q_i;
      logic [RW-1:0]       n_i;
      logic [2:0][MW-1:0]  mag_i;
      logic [2:0]          neg_i;
      logic [2:0][RW:0]    rem_n;
      logic [2:0][QW-1:0]  q_n;
      logic [MW+FB-1:0]    xw;
      logic [RW:0]         rem_s;
      logic [RW+1:0]       t;
      logic [RW+1:0]       n_ext;

      if (j == 0) begin : g_first
         assign vld_i = sq_vld_ff[RW-1];
         assign rem_i = '0;
         assign q_i   = '0;
         assign n_i   = sq_root_ff[RW-1];
         assign mag_i = sq_mag_ff[RW-1];
         assign neg_i = sq_neg_ff[RW-1];
      end else begin : g_next
         assign vld_i = dv_vld_ff[j-1];
         assign rem_i = dv_rem_ff[j-1];
         assign q_i   = dv_q_ff[j-1];
         assign n_i   = dv_n_ff[j-1];
         assign mag_i = dv_mag_ff[j-1];
         assign neg_i = dv_neg_ff[j-1];
      end

      always_comb begin
         xw    = '0;
         rem_s = '0;
         t     = '0;
         n_ext = (RW+2)'(n_i);
         for (int c = 0; c < 3; c++) begin
            xw = {mag_i[c], {FB{1'b0}}};
            if (j == 0) begin
               rem_s = (RW+1)'(xw >> QW);
            end else begin
               rem_s = rem_i[c];
            end
            t = {rem_s, xw[QW-1-j]};
            if (t >= n_ext) begin
               rem_n[c] = (RW+1)'(t - n_ext);
               q_n[c]   = {q_i[c][QW-2:0], 1'b1};
            end else begin
               rem_n[c] = t[RW:0];
               q_n[c]   = {q_i[c][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j] <= 1'b0;
         end else if (en) begin
            dv_vld_ff[j] <= vld_i;
         end
         if (en) begin
            dv_rem_ff[j] <= rem_n;
            dv_q_ff[j]   <= q_n;
            dv_n_ff[j]   <= n_i;
            dv_mag_ff[j] <= mag_i;
            dv_neg_ff[j] <= neg_i;
         end
      end
   end

   // sign and zero norm
   logic                      o_vld_ff;
   lav_pkg::unit_vec_type     o_f_ff;
   lav_pkg::unit_vec_type     o_f_in;
   logic [FW-1:0]             qx;

   always_comb begin
      qx = '0;
      for (int c = 0; c < 3; c++) begin
         qx = FW'(dv_q_ff[QW-1][c]);
         if (dv_n_ff[QW-1] == '0) begin
            o_f_in[c] = '0;
         end else begin
            o_f_in[c] = dv_neg_ff[QW-1][c] ? -qx : qx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (en) begin
         o_vld_ff <= dv_vld_ff[QW-1];
      end
      if (en) begin
         o_f_ff <= o_f_in;
      end
   end

   assign out_valid = o_vld_ff;
   assign out_f     = o_f_ff;

endmodule

@@ hw/rtl/lav_cols.sv @@
`timescale 1ns / 1ps

module lav_cols (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  lav_pkg::mat_type         in_mat,
   output logic                     in_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_column,
   output logic [31:0]              rsp_elem_row0,
   output logic [31:0]              rsp_elem_row1,
   output logic [31:0]              rsp_elem_row2,
   output logic [31:0]              rsp_elem_row3,
   output logic                     rsp_last
);

   logic                  busy_ff;
   logic [1:0]            cnt_ff;
   lav_pkg::mat_type      mat_ff;
   logic                  fire;
   logic                  done;
   logic                  load;

   assign fire     = busy_ff && !rsp_stall;
   assign done     = fire && (cnt_ff == lav_pkg::LAST_COL);
   assign in_ready = !busy_ff || done;
   assign load     = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (fire) begin
         cnt_ff <= cnt_ff + 2'd1;
      end
      if (load) begin
         mat_ff <= in_mat;
      end
   end

   assign rsp_valid     = busy_ff;
   assign rsp_column    = cnt_ff;
   assign rsp_elem_row0 = mat_ff[cnt_ff][0];
   assign rsp_elem_row1 = mat_ff[cnt_ff][1];
   assign rsp_elem_row2 = mat_ff[cnt_ff][2];
   assign rsp_last      = (cnt_ff == lav_pkg::LAST_COL);
   assign rsp_elem_row3 = rsp_last ? lav_pkg::ONE_Q : '0;

endmodule

@@ hw/rtl/lav_check.sv @@
`timescale 1ns / 1ps

module lav_check (
   input logic          clock,
   input logic          reset,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input logic [1:0]    rsp_column,
   input logic [31:0]   rsp_elem_row3,
   input logic          rsp_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_column))
      else $error("stalled item changed");

   a_next_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last
      |=> rsp_valid && (rsp_column == $past(rsp_column) + 2'd1))
      else $error("column sequence broken");

   a_last_row3: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_column == lav_pkg::LAST_COL))
                 && (rsp_elem_row3 == (rsp_last ? lav_pkg::ONE_Q : 32'd0)))
      else $error("last flag or row 3 wrong");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind look_at_view_matrix lav_check u_lav_check (.*);

@@ bench/tb_look_at_view_matrix.sv @@
`timescale 1ns / 1ps

module tb_look_at_view_matrix;

   typedef logic signed [63:0] s64_type;

   typedef struct packed {
      logic [31:0] eye_x, eye_y, eye_z;
      logic [31:0] ctr_x, ctr_y, ctr_z;
      logic [31:0] up_x, up_y, up_z;
      logic        fixed_view;   // eye == center: matrix known by inspection
   } view_req_type;

   typedef struct packed {
      logic [1:0]  column;
      logic [31:0] r0, r1, r2, r3;
      logic        last;
   } column_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   logic [31:0] req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic [31:0] req_up_x = '0, req_up_y = '0, req_up_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_column;
   logic [31:0] rsp_elem_row0, rsp_elem_row1, rsp_elem_row2, rsp_elem_row3;
   logic rsp_last;

   column_type pending_cols[$];
   int errors = 0;
   int stall_mode = 0;
   int stall_cnt = 0;

   always #5 clock = ~clock;

   look_at_view_matrix i_dut (.*);

   function automatic logic [63:0] mag64(s64_type v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [63:0] root_floor(logic [127:0] x);
      logic [63:0] r, c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= x) r = c;
      end
      return r;
   endfunction

   task automatic unit_vec(input s64_type v[3], output s64_type o[3]);
      logic [127:0] acc, q;
      logic [63:0] n, m;
      acc = '0;
      for (int c = 0; c < 3; c++) begin
         m = mag64(v[c]);
         acc = acc + {64'd0, m} * {64'd0, m};
      end
      n = root_floor(acc);
      for (int c = 0; c < 3; c++) begin
         if (n == 0) begin
            o[c] = 0;
         end else begin
            q = ({64'd0, mag64(v[c])} << lav_pkg::FRAC_BITS) / {64'd0, n};
            o[c] = v[c] < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
         end
      end
   endtask

   function automatic s64_type trunc_frac(s64_type x);
      logic [63:0] m;
      m = mag64(x) >> lav_pkg::FRAC_BITS;
      return x < 0 ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [31:0] clamp32(s64_type x);
      if (x > 64'sd2147483647) return 32'h7FFFFFFF;
      if (x < -64'sd2147483648) return 32'h80000000;
      return x[31:0];
   endfunction

   task automatic predict_view(input view_req_type q);
      s64_type eye[3], up[3], d[3], f[3], sr[3], s[3], u[3], dse, due, dfe;
      column_type col;
      eye = '{$signed(q.eye_x), $signed(q.eye_y), $signed(q.eye_z)};
      up = '{$signed(q.up_x), $signed(q.up_y), $signed(q.up_z)};
      d[0] = $signed(q.ctr_x) - eye[0];
      d[1] = $signed(q.ctr_y) - eye[1];
      d[2] = $signed(q.ctr_z) - eye[2];
      unit_vec(d, f);
      sr[0] = f[1] * up[2] - f[2] * up[1];
      sr[1] = f[2] * up[0] - f[0] * up[2];
      sr[2] = f[0] * up[1] - f[1] * up[0];
      unit_vec(sr, s);
      u[0] = trunc_frac(s[1] * f[2] - s[2] * f[1]);
      u[1] = trunc_frac(s[2] * f[0] - s[0] * f[2]);
      u[2] = trunc_frac(s[0] * f[1] - s[1] * f[0]);
      for (int c = 0; c < 3; c++) begin
         col.column = 2'(c);
         col.r0 = clamp32(s[c]);
         col.r1 = clamp32(u[c]);
         col.r2 = clamp32(-f[c]);
         col.r3 = '0;
         col.last = 1'b0;
         pending_cols.push_back(col);
      end
      dse = trunc_frac(s[0] * eye[0] + s[1] * eye[1] + s[2] * eye[2]);
      due = trunc_frac(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2]);
      dfe = trunc_frac(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]);
      col.column = lav_pkg::LAST_COL;
      col.r0 = clamp32(-dse);
      col.r1 = clamp32(-due);
      col.r2 = clamp32(dfe);
      col.r3 = 32'h00010000;
      col.last = 1'b1;
      pending_cols.push_back(col);
   endtask

   task automatic send_view(input view_req_type q);
      column_type col;
      req_eye_x <= q.eye_x;
      req_eye_y <= q.eye_y;
      req_eye_z <= q.eye_z;
      req_center_x <= q.ctr_x;
      req_center_y <= q.ctr_y;
      req_center_z <= q.ctr_z;
      req_up_x <= q.up_x;
      req_up_y <= q.up_y;
      req_up_z <= q.up_z;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (q.fixed_view) begin
         for (int c = 0; c < 4; c++) begin
            col = '{column: 2'(c), r0: 32'd0, r1: 32'd0, r2: 32'd0,
                    r3: (c == 3) ? 32'h00010000 : 32'd0, last: (c == 3)};
            pending_cols.push_back(col);
         end
      end else begin
         predict_view(q);
      end
   endtask

   function automatic logic [31:0] rand_coord(int kind);
      int pick;
      case (kind)
         0: return $urandom;
         1: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
         default: begin
            pick = $urandom_range(0, 5);
            case (pick)
               0: return 32'h0;
               1: return 32'h7FFFFFFF;
               2: return 32'h80000000;
               3: return 32'h1;
               4: return 32'hFFFFFFFF;
               default: return 32'h00010000;
            endcase
         end
      endcase
   endfunction

   function automatic view_req_type rand_view();
      view_req_type q;
      int kind, shape;
      kind = $urandom_range(0, 9) < 6 ? 1 : ($urandom_range(0, 1) ? 0 : 2);
      q = '{rand_coord(kind), rand_coord(kind), rand_coord(kind),
            rand_coord(kind), rand_coord(kind), rand_coord(kind),
            rand_coord(kind), rand_coord(kind), rand_coord(kind), 1'b0};
      shape = $urandom_range(0, 19);
      if (shape == 0) begin
         q.ctr_x = q.eye_x;
         q.ctr_y = q.eye_y;
         q.ctr_z = q.eye_z;
      end else if (shape == 1 && kind == 1) begin
         q.up_x = q.ctr_x - q.eye_x;
         q.up_y = q.ctr_y - q.eye_y;
         q.up_z = q.ctr_z - q.eye_z;
      end else if (shape == 2) begin
         q.up_x = '0;
         q.up_y = '0;
         q.up_z = '0;
      end
      return q;
   endfunction

   always @(posedge clock) begin
      column_type exp_col;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt % 97 == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= $urandom_range(0, 1);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
         if (rsp_valid && !rsp_stall) begin
            if (pending_cols.size() == 0) begin
               $display("%0t: unexpected column %0d", $time, rsp_column);
               errors++;
            end else begin
               exp_col = pending_cols.pop_front();
               if (rsp_column !== exp_col.column || rsp_elem_row0 !== exp_col.r0 ||
                   rsp_elem_row1 !== exp_col.r1 || rsp_elem_row2 !== exp_col.r2 ||
                   rsp_elem_row3 !== exp_col.r3 || rsp_last !== exp_col.last) begin
                  $display("%0t: expected col %0d %h %h %h %h last %b", $time,
                           exp_col.column, exp_col.r0, exp_col.r1, exp_col.r2,
                           exp_col.r3, exp_col.last);
                  $display("%0t: actual   col %0d %h %h %h %h last %b", $time,
                           rsp_column, rsp_elem_row0, rsp_elem_row1, rsp_elem_row2,
                           rsp_elem_row3, rsp_last);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("[look_at_view_matrix] ERROR");
      $finish;
   end

   initial begin
      view_req_type dir_tbl[13];
      int burst, sent;
      dir_tbl = '{
         '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1},
         '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
           32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1},
         '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
           32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1},
         '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF0000,
           32'h0, 32'h00010000, 32'h0, 1'b0},
         '{32'h0, 32'h0, 32'h00050000, 32'h0, 32'h0, 32'h0,
           32'h0, 32'h00010000, 32'h0, 1'b0},
         '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
           32'h7FFFFFFF, 32'h0, 32'h00010000, 32'h0, 1'b0},
         '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
           32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0},
         '{32'h0, 32'h0, 32'h0, 32'h00010000, 32'h00020000, 32'h00030000,
           32'h00020000, 32'h00040000, 32'h00060000, 1'b0},
         '{32'h00010000, 32'h00020000, 32'h00030000, 32'h00040000, 32'h00050000,
           32'h00060000, 32'h0, 32'h0, 32'h0, 1'b0},
         '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0,
           32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0},
         '{32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 1'b0},
         '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0,
           32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF, 1'b0},
         '{32'h12345678, 32'hEDCBA987, 32'h0F0F0F0F, 32'hF0F0F0F0, 32'h5A5A5A5A,
           32'hA5A5A5A5, 32'h00000001, 32'h80000001, 32'h7FFFFFFE, 1'b0}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_tbl[i]) begin
         send_view(dir_tbl[i]);
         if (i % 4 == 3) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      sent = 0;
      while (sent < 180) begin
         burst = $urandom_range(1, 10);
         for (int k = 0; k < burst; k++) begin
            send_view(rand_view());
            sent++;
         end
         req_valid <= 1'b0;
         if (sent >= 90 && sent - burst < 90) begin
            while (pending_cols.size() != 0) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
      while (pending_cols.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("[look_at_view_matrix] OK");
      end else begin
         $display("[look_at_view_matrix] ERROR");
      end
      $finish;
   end

endmodule
